// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication into the next cycle, checking suspended while reset is low.
`define SKRR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("skrr assertion failed");

// Implication into the next cycle, checked through reset as well.
`define SKRR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("skrr assertion failed");

`endif

// ===== sv/skrr_pkg.sv =====
// Shared constants and types for the scalar Kalman range-rescale filter.
package skrr_pkg;

  // Q16.16 thresholds used by the range rule
  localparam logic signed [31:0] FIX_FOUR = 32'sd262144;
  localparam logic signed [31:0] FIX_FIVE = 32'sd327680;
  localparam logic signed [31:0] FIX_SIX  = 32'sd393216;

  // Reset values of state and registers
  localparam logic signed [31:0] RESET_ESTIMATE      = 32'sd262144;
  localparam logic [31:0]        RESET_COVARIANCE    = 32'd1311;
  localparam logic [31:0]        RESET_PROCESS_NOISE = 32'd655;
  localparam logic [31:0]        RESET_MEASURE_NOISE = 32'd16384;

  // Config port: byte address, register select bit
  localparam int unsigned CFG_AW      = 3;
  localparam int unsigned CFG_SEL_BIT = 2;
  localparam logic REG_PROCESS_NOISE = 1'b0;
  localparam logic REG_MEASURE_NOISE = 1'b1;

  // Gain divider: one quotient bit per step
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CW    = 4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the accepted sample
    logic prep;      // range rule, predicted covariance, divider init
    logic div_step;  // one restoring division step
    logic mul_est;   // product gain * (sample - estimate)
    logic mul_cov;   // product (1 - gain) * predicted
    logic upd_est;   // fold the estimate product into the estimate
    logic upd_cov;   // fold the covariance product into the covariance
    logic out_load;  // copy the estimate into the output register
  } skrr_cmd_t;

endpackage

// ===== sv/skrr_sample_if.sv =====
// Input channel carrying one Q16.16 sample per beat.
interface skrr_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== sv/skrr_estimate_if.sv =====
// Result channel carrying one Q16.16 estimate per beat.
interface skrr_estimate_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] estimate_out;

  modport source (output valid, output estimate_out, input ready);
  modport sink   (input valid, input estimate_out, output ready);
endinterface

// ===== sv/skrr_ctrl.sv =====
// Sequencer for the filter update: issues datapath commands, owns the handshakes.
module skrr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output skrr_pkg::skrr_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL_EST,
    ST_MUL_COV,
    ST_COV,
    ST_OUT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [skrr_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        accept;
  logic                        slot_free;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  // next state and counter
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == skrr_pkg::DIV_CW'(skrr_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_MUL_EST;
        end
      end
      ST_MUL_EST: state_nxt = ST_MUL_COV;
      ST_MUL_COV: state_nxt = ST_COV;
      ST_COV:     state_nxt = ST_OUT;
      ST_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.capture  = accept;
    cmd.prep     = (state_r == ST_PREP);
    cmd.div_step = (state_r == ST_DIV);
    cmd.mul_est  = (state_r == ST_MUL_EST);
    cmd.mul_cov  = (state_r == ST_MUL_COV);
    cmd.upd_est  = (state_r == ST_MUL_COV);
    cmd.upd_cov  = (state_r == ST_COV);
    cmd.out_load = (state_r == ST_OUT) && slot_free;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/skrr_dpath.sv =====
// Filter datapath: range rule, serial gain divider, shared multiplier, state.
module skrr_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  skrr_pkg::skrr_cmd_t cmd,
  input  logic signed [31:0]  sample,
  input  logic [31:0]         process_noise,
  input  logic [31:0]         measure_noise,
  output logic signed [31:0]  estimate_out
);

  logic signed [31:0] sample_r;
  logic signed [31:0] est_r, est_nxt;
  logic [31:0]        cov_r;
  logic [31:0]        pred_r;
  logic [32:0]        den_r;
  logic [32:0]        rem_r;
  logic [15:0]        quo_r;
  logic               mnz_r;
  logic signed [50:0] prod_r;
  logic signed [31:0] out_r;

  logic signed [31:0] est_rule;
  logic [32:0]        pred_sum;
  logic [31:0]        pred_sat;
  logic [33:0]        rem_sh;
  logic [15:0]        gain;
  logic signed [32:0] diff;
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [34:0] delta;
  logic signed [35:0] est_sum;

  // range rule applied to the held estimate
  always_comb begin
    est_rule = est_r;
    if (sample_r != skrr_pkg::FIX_FOUR) begin
      if (sample_r > skrr_pkg::FIX_FIVE) begin
        if (est_r < skrr_pkg::FIX_SIX) begin
          // doubling saturates when the top two bits differ
          if (est_r[31] != est_r[30]) begin
            est_rule = est_r[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end else begin
            est_rule = {est_r[30:0], 1'b0};
          end
        end
      end else if (est_r > skrr_pkg::FIX_FIVE) begin
        est_rule = {1'b0, est_r[31:1]};
      end
    end
  end

  // predicted covariance, saturated
  assign pred_sum = {1'b0, cov_r} + {1'b0, process_noise};
  assign pred_sat = pred_sum[32] ? 32'hFFFF_FFFF : pred_sum[31:0];

  // restoring division step
  assign rem_sh = {rem_r, 1'b0};

  // gain of one (no measurement noise) saturates; zero denominator gives zero
  assign gain = mnz_r ? ((pred_r != '0) ? 16'hFFFF : 16'h0000) : quo_r;

  // shared multiplier operands
  assign diff = {sample_r[31], sample_r} - {est_r[31], est_r};
  always_comb begin
    if (cmd.mul_cov) begin
      mul_a = {1'b0, 17'h10000 - {1'b0, gain}};
      mul_b = {1'b0, pred_r};
    end else begin
      mul_a = {2'b00, gain};
      mul_b = diff;
    end
  end

  // estimate plus floored delta, clamped to 32 bits
  assign delta   = prod_r[50:16];
  assign est_sum = {{4{est_r[31]}}, est_r} + {delta[34], delta};
  always_comb begin
    if (est_sum[35:31] == 5'b00000 || est_sum[35:31] == 5'b11111) begin
      est_nxt = est_sum[31:0];
    end else begin
      est_nxt = est_sum[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= skrr_pkg::RESET_ESTIMATE;
      cov_r <= skrr_pkg::RESET_COVARIANCE;
    end else begin
      if (cmd.prep) begin
        est_r <= est_rule;
      end else if (cmd.upd_est) begin
        est_r <= est_nxt;
      end
      if (cmd.upd_cov) begin
        cov_r <= prod_r[47:16];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= sample;
    end
    if (cmd.prep) begin
      pred_r <= pred_sat;
      den_r  <= {1'b0, pred_sat} + {1'b0, measure_noise};
      rem_r  <= {1'b0, pred_sat};
      quo_r  <= '0;
      mnz_r  <= (measure_noise == '0);
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= 33'(rem_sh - {1'b0, den_r});
        quo_r <= {quo_r[14:0], 1'b1};
      end else begin
        rem_r <= rem_sh[32:0];
        quo_r <= {quo_r[14:0], 1'b0};
      end
    end
    if (cmd.mul_est || cmd.mul_cov) begin
      prod_r <= 51'(mul_a * mul_b);
    end
    if (cmd.out_load) begin
      out_r <= est_r;
    end
  end

  assign estimate_out = out_r;

endmodule

// ===== sv/scalar_kalman_range_rescale_core.sv =====
// Top level of the scalar Kalman filter with range rescaling.
//
// Usage:
//   in_ch carries one signed Q16.16 sample per beat (valid/ready), out_ch one
//   signed Q16.16 estimate per beat. Every sample gives exactly one estimate.
//   Noise covariances are written through the APB-style cfg_ port: offset 0
//   is process_noise, offset 4 is measure_noise; write only while idle.
// Timing:
//   A sample is taken in the idle cycle. One sample is worked on at a time, so
//   no new sample is taken until its estimate is loaded; the steps are the idle
//   accept cycle, a setup step, the bit-serial gain divider, two passes through
//   the single shared multiplier, the covariance writeback and the output load.
// Stall:
//   The result sits in an output register; a new sample may be accepted while
//   it waits. If the receiver still holds off when the next estimate is done,
//   the sequencer waits and in_ch.ready stays low.
// Reset:
//   rst_n (synchronous, active low) drops out valid, returns the sequencer to
//   idle and restores estimate 4.0, covariance 1311 and the noise registers.
module scalar_kalman_range_rescale_core (
  input  logic                          clk,
  input  logic                          rst_n,
  skrr_sample_if.sink                   in_ch,
  skrr_estimate_if.source               out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [skrr_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [31:0]         process_noise_r;
  logic [31:0]         measure_noise_r;
  logic                cfg_wr;
  logic                reg_sel;
  skrr_pkg::skrr_cmd_t cmd;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[skrr_pkg::CFG_SEL_BIT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      process_noise_r <= skrr_pkg::RESET_PROCESS_NOISE;
      measure_noise_r <= skrr_pkg::RESET_MEASURE_NOISE;
    end else if (cfg_wr) begin
      if (reg_sel == skrr_pkg::REG_PROCESS_NOISE) begin
        process_noise_r <= cfg_pwdata;
      end else begin
        measure_noise_r <= cfg_pwdata;
      end
    end
  end

  assign cfg_prdata = (reg_sel == skrr_pkg::REG_MEASURE_NOISE) ? measure_noise_r
                                                               : process_noise_r;

  // sequencer
  skrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // arithmetic
  skrr_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sample        (in_ch.sample),
    .process_noise (process_noise_r),
    .measure_noise (measure_noise_r),
    .estimate_out  (out_ch.estimate_out)
  );

endmodule

// ===== sv/skrr_checker.sv =====
// Port-level checks for the filter core, bound to the top level.
`include "assert_macros.svh"

module skrr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_estimate
);

  // a stalled result beat keeps its value
  `SKRR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_estimate))

  // reset leaves no result pending and the input open
  `SKRR_ASSERT_NEXT_ALWAYS(a_rst_clear, clk, !rst_n, !out_valid && in_ready)

  // one sample in flight: ready drops right after an input beat
  `SKRR_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind scalar_kalman_range_rescale_core skrr_checker u_skrr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_estimate (out_ch.estimate_out)
);
